/* hdl/mtsed_pkg.sv */
// ----------------------------------------------------------------------------
// mtsed_pkg
// Shared types, constants and character tables for the markup tag strip and
// entity decode block.
// ----------------------------------------------------------------------------
package mtsed_pkg;

  // sizes
  localparam int unsigned MaxResults = 6;
  localparam int unsigned HeldDepth  = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CntW       = 3;

  // tag match position once the tag can no longer be <br/>
  localparam logic [2:0] TagFail = 3'd7;
  localparam logic [2:0] TagFull = 3'd4;

  // character codes
  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChQuot    = 8'h22;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChNone    = 8'h00;

  // parse mode, one-hot
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_TAG   = 3'b010,
    MODE_ENT   = 3'b100
  } mode_e;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_word_t;

  // command from front to back: the result bytes of one input word
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;
    logic [CntW-1:0]            cnt;
    logic                       last;
  } cmd_t;

  // ascii case folding, A-Z only
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // "<br/" pattern
  function automatic logic [7:0] br_char(input logic [1:0] pos);
    logic [7:0] r;
    case (pos)
      2'd0:    r = ChLt;
      2'd1:    r = 8'h62;
      2'd2:    r = 8'h72;
      default: r = 8'h2F;
    endcase
    return r;
  endfunction

  // entity patterns after '&': lt; gt; amp; quot; (zero past the end)
  function automatic logic [7:0] ent_pat_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] r;
    r = ChNone;
    case (k)
      2'd0: begin
        case (idx)
          3'd0:    r = 8'h6C;
          3'd1:    r = 8'h74;
          3'd2:    r = ChSemi;
          default: r = ChNone;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0:    r = 8'h67;
          3'd1:    r = 8'h74;
          3'd2:    r = ChSemi;
          default: r = ChNone;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    r = 8'h61;
          3'd1:    r = 8'h6D;
          3'd2:    r = 8'h70;
          3'd3:    r = ChSemi;
          default: r = ChNone;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    r = 8'h71;
          3'd1:    r = 8'h75;
          3'd2:    r = 8'h6F;
          3'd3:    r = 8'h74;
          3'd4:    r = ChSemi;
          default: r = ChNone;
        endcase
      end
    endcase
    return r;
  endfunction

  // decoded character of an entity
  function automatic logic [7:0] ent_out_char(input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = ChLt;
      2'd1:    r = ChGt;
      2'd2:    r = ChAmp;
      default: r = ChQuot;
    endcase
    return r;
  endfunction

endpackage

/* hdl/mtsed_front.sv */
// ----------------------------------------------------------------------------
// mtsed_front
// Parser front: takes one text word per cycle when accepted, tracks tag and
// entity state, and builds the list of result bytes that the word causes.
// ----------------------------------------------------------------------------
module mtsed_front
  import mtsed_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_word_t in_word_i,
  output logic     cmd_wr_o,
  output cmd_t     cmd_o
);

  mode_e                      mode_q, mode_d;
  logic [2:0]                 pos_q, pos_d;
  logic [3:0]                 cand_q, cand_d;
  logic [2:0]                 len_q, len_d;
  logic [HeldDepth-1:0][7:0]  held_q, held_d;

  logic [MaxResults-1:0][7:0] data;
  logic [CntW-1:0]            cnt;
  logic [7:0]                 b;
  logic [7:0]                 c;
  logic [3:0]                 mask;
  logic                       flush_now;
  logic                       plain_now;
  logic                       live;

  assign b    = in_word_i.in_byte;
  assign c    = fold(b);
  assign live = accept_i && (b != ChNone);

  // entity candidates that still match with this letter
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mask[k] = cand_q[k] && (ent_pat_char(2'(k), len_q) == c);
    end
  end

  // next state and result list
  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    cand_d    = cand_q;
    len_d     = len_q;
    held_d    = held_q;
    data      = '0;
    cnt       = '0;
    flush_now = 1'b0;
    plain_now = 1'b0;

    if (live) begin
      unique case (mode_q)
        MODE_TAG: begin
          if (b == ChGt) begin
            if (pos_q == TagFull) begin
              data[0] = ChNewline;
              cnt     = CntW'(1);
            end
            mode_d = MODE_PLAIN;
            pos_d  = '0;
          end else if (pos_q < TagFull && c == br_char(pos_q[1:0])) begin
            pos_d = pos_q + 3'd1;
          end else begin
            pos_d = TagFail;
          end
        end
        MODE_ENT: begin
          if (mask == 4'd0) begin
            flush_now = 1'b1;
            plain_now = 1'b1;
          end else if (c == ChSemi) begin
            // lowest surviving candidate wins
            if (mask[0]) begin
              data[0] = ent_out_char(2'd0);
            end else if (mask[1]) begin
              data[0] = ent_out_char(2'd1);
            end else if (mask[2]) begin
              data[0] = ent_out_char(2'd2);
            end else begin
              data[0] = ent_out_char(2'd3);
            end
            cnt    = CntW'(1);
            mode_d = MODE_PLAIN;
            cand_d = '0;
            len_d  = '0;
          end else if (len_q < 3'(HeldDepth)) begin
            held_d[len_q[1:0]] = b;
            len_d              = len_q + 3'd1;
            cand_d             = mask;
          end else begin
            flush_now = 1'b1;
            plain_now = 1'b1;
          end
        end
        default: begin
          plain_now = 1'b1;
        end
      endcase
    end

    // broken entity: '&' and the held letters
    if (flush_now) begin
      data[0] = ChAmp;
      for (int i = 0; i < HeldDepth; i++) begin
        data[i+1] = held_q[i];
      end
      cnt    = CntW'(1) + len_q;
      mode_d = MODE_PLAIN;
      len_d  = '0;
      cand_d = '0;
    end

    // byte handled as ordinary text
    if (plain_now) begin
      if (b == ChLt) begin
        mode_d = MODE_TAG;
        pos_d  = 3'd1;
      end else if (b == ChAmp) begin
        mode_d = MODE_ENT;
        cand_d = 4'hF;
        len_d  = '0;
      end else begin
        for (int i = 0; i < MaxResults; i++) begin
          if (cnt == CntW'(i)) begin
            data[i] = b;
          end
        end
        cnt = cnt + CntW'(1);
      end
    end

    // end of text: flush a partial entity and return to plain text
    if (accept_i && in_word_i.end_of_text) begin
      if (mode_d == MODE_ENT) begin
        if (cnt == '0) begin
          data[0] = ChAmp;
          for (int i = 0; i < HeldDepth; i++) begin
            data[i+1] = held_d[i];
          end
          cnt = CntW'(1) + len_d;
        end else begin
          for (int i = 0; i < MaxResults; i++) begin
            if (cnt == CntW'(i)) begin
              data[i] = ChAmp;
            end
          end
          cnt = cnt + CntW'(1);
        end
      end
      mode_d = MODE_PLAIN;
      pos_d  = '0;
      cand_d = '0;
      len_d  = '0;
    end
  end

  assign cmd_o.data = data;
  assign cmd_o.cnt  = cnt;
  assign cmd_o.last = in_word_i.end_of_text;
  assign cmd_wr_o   = accept_i && ((cnt != '0) || in_word_i.end_of_text);

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      pos_q  <= '0;
      cand_q <= '0;
      len_q  <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      cand_q <= cand_d;
      len_q  <= len_d;
    end
  end

  // held letters, no reset
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

/* hdl/mtsed_fifo.sv */
// ----------------------------------------------------------------------------
// mtsed_fifo
// Small command queue between parser front and output back.
// ----------------------------------------------------------------------------
module mtsed_fifo
  import mtsed_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  cmd_t              mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              do_wr;
  logic              do_rd;

  assign full_o    = (count_q == CountW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CountW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* hdl/mtsed_back.sv */
// ----------------------------------------------------------------------------
// mtsed_back
// Output back: walks the bytes of the head command, one result word per pop,
// and gives a bare end marker for a command without bytes.
// ----------------------------------------------------------------------------
module mtsed_back
  import mtsed_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      head_i,
  input  logic      head_valid_i,
  input  logic      pop_i,
  output logic      head_done_o,
  output out_word_t out_word_o,
  output logic      empty_o
);

  logic [CntW-1:0] idx_q, idx_d;
  logic            last_byte;
  logic            bare;
  logic            take;
  logic [7:0]      sel_byte;

  assign bare      = (head_i.cnt == '0);
  assign last_byte = bare || (idx_q == head_i.cnt - CntW'(1));
  assign take      = pop_i && head_valid_i;
  assign empty_o   = !head_valid_i;
  assign head_done_o = take && last_byte;

  // byte select
  always_comb begin
    sel_byte = ChNone;
    for (int i = 0; i < MaxResults; i++) begin
      if (idx_q == CntW'(i)) begin
        sel_byte = head_i.data[i];
      end
    end
  end

  assign out_word_o.out_byte  = bare ? ChNone : sel_byte;
  assign out_word_o.out_valid = !bare;
  assign out_word_o.out_last  = head_i.last && last_byte;

  // position within the head command
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_byte ? '0 : idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

/* hdl/markup_tag_strip_entity_decode_core.sv */
// ----------------------------------------------------------------------------
// markup_tag_strip_entity_decode_core
// Strips markup tags and decodes character entities from a byte stream.
// ----------------------------------------------------------------------------
// Path: a text word's results are registered in the command queue, then shown.
// Throughput: one text word per cycle while the queue is not full; results leave
//   one per pop; n results of a word take n pops; QueueDepth commands buffer that.
// Reset: clears parse state, queue and output position; held entity letters
//   are not cleared. No clearing pass, input taken as soon as reset is released.
module markup_tag_strip_entity_decode_core
  import mtsed_pkg::*;
#(
  parameter int unsigned QueueDepth = mtsed_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_data_o
);

  logic accept;
  logic cmd_wr;
  cmd_t cmd;
  cmd_t head;
  logic q_full;
  logic q_empty;
  logic head_done;

  assign full   = q_full;
  assign accept = push && !q_full;

  // parser front
  mtsed_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_data_i),
    .cmd_wr_o  (cmd_wr),
    .cmd_o     (cmd)
  );

  // command queue
  mtsed_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_wr),
    .wr_data_i (cmd),
    .rd_i      (head_done),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // output back
  mtsed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_i        (pop),
    .head_done_o  (head_done),
    .out_word_o   (out_data_o),
    .empty_o      (empty)
  );

endmodule

/* hdl/mtsed_checker.sv */
// ----------------------------------------------------------------------------
// mtsed_checker
// Port-level checks on the input and result sides of the markup strip block.
// ----------------------------------------------------------------------------
module mtsed_checker
  import mtsed_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_word_t out_data_o
);

  // a waiting word that is not taken stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result word changed while stalled");

  // a bare end marker always closes the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.out_valid) |-> out_data_o.out_last)
    else $error("bare marker without last");

  // a bare end marker carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.out_valid) |-> (out_data_o.out_byte == ChNone))
    else $error("bare marker with nonzero byte");

  // an emitted character is never the zero code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.out_valid) |-> (out_data_o.out_byte != ChNone))
    else $error("zero character emitted");

  // the input side only fills up after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

endmodule

bind markup_tag_strip_entity_decode_core mtsed_checker u_mtsed_checker (.*);
